// ===== sv/chat_frame_deframer_liveness_top_defines.svh =====
// ----------------------------------------------------------------------------
// Chat frame deframer assertion macros
// Shared property forms for the port-level checker of the deframer.
// ----------------------------------------------------------------------------
`ifndef CHAT_FRAME_DEFRAMER_LIVENESS_TOP_DEFINES_SVH
`define CHAT_FRAME_DEFRAMER_LIVENESS_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFDL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CFDL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/cfdl_pkg.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfdl_pkg;

  // Default values of the top-level parameters.
  localparam int CHANNELS_DEF      = 2;
  localparam int SEGMENT_BYTES_DEF = 44;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PING_AFTER    = 2'd0,
    CFG_TIMEOUT_AFTER = 2'd1
  } cfg_idx_t;

  localparam logic [CFG_DATA_W-1:0] PING_AFTER_RST    = 4'd2;
  localparam logic [CFG_DATA_W-1:0] TIMEOUT_AFTER_RST = 4'd5;

  // Protocol bytes.
  localparam logic [7:0] ESCAPE_BYTE = 8'h5C;
  localparam logic [7:0] CHR_MSG     = 8'h4D;  // 'M'
  localparam logic [7:0] CHR_NAME    = 8'h48;  // 'H'
  localparam logic [7:0] CHR_PING    = 8'h50;  // 'P'
  localparam logic [7:0] CHR_WAVE    = 8'h57;  // 'W'

  // Field widths of the per-channel state.
  localparam int LEN_W  = 7;
  localparam int SEEN_W = 8;
  localparam int HELD_W = 7;   // holds any segment size up to 127
  localparam int CNT_W  = 4;
  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  // Result queue depth.
  localparam int FIFO_DEPTH = 4;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESCAPED = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_TRAILER = 3'd4
  } phase_t;

  typedef enum logic [3:0] {
    EV_NONE      = 4'd0,
    EV_MSG_BYTE  = 4'd1,
    EV_NAME_BYTE = 4'd2,
    EV_MSG_END   = 4'd3,
    EV_NAME_END  = 4'd4,
    EV_LEFT      = 4'd5,
    EV_WHO       = 4'd6,
    EV_HANDSHAKE = 4'd7,
    EV_PING      = 4'd8,
    EV_TIMEOUT   = 4'd9
  } event_t;

  // One entry of the per-channel state memory. All zero is the reset state.
  typedef struct packed {
    phase_t            phase;
    logic              is_name;
    logic [LEN_W-1:0]  length;
    logic [SEEN_W-1:0] seen;
    logic [HELD_W-1:0] held;
    logic              alive;
    logic              name_known;
    logic [CNT_W-1:0]  idle;
  } entry_t;

  // One result item.
  typedef struct packed {
    event_t     ev;
    logic       ch;
    logic [7:0] data;
    logic       empty;
    logic       last;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/cfdl_if.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer channel interfaces
// Valid/ready request channels for received bytes and ticks and for result events.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfdl_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       channel;
  logic [7:0] rx_byte;

  modport source (output valid, output operation, output channel, output rx_byte,
                  input ready);
  modport sink   (input valid, input operation, input channel, input rx_byte,
                  output ready);
endinterface

interface cfdl_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_res;
  logic       out_channel;
  logic [7:0] data;
  logic       segment_empty;
  logic       last;

  modport source (output valid, output event_res, output out_channel, output data,
                  output segment_empty, output last, input ready);
  modport sink   (input valid, input event_res, input out_channel, input data,
                  input segment_empty, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/cfdl_res_fifo.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer result queue
// Small queue taking up to two results a cycle and handing out one.
// ----------------------------------------------------------------------------
`default_nettype none

module cfdl_res_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [1:0]     push_n,
  input  cfdl_pkg::res_t      push_a,
  input  cfdl_pkg::res_t      push_b,
  output logic                space_ok,
  cfdl_out_if.source          out_res
);

  localparam int DEPTH = cfdl_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  cfdl_pkg::res_t buf_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r;
  logic [PW-1:0]  wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r;
  logic [PW:0]    count_r;
  logic [PW:0]    count_nxt;
  logic           pop;
  cfdl_pkg::res_t head;

  assign pop      = out_res.valid && out_res.ready;
  // Room for the largest push of one cycle, without counting a pop.
  assign space_ok = (count_r <= (PW+1)'(DEPTH - 2));

  assign wr_ptr_nxt = wr_ptr_r + PW'(1);
  assign count_nxt  = count_r + (PW+1)'(push_n) - (PW+1)'(pop);

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      buf_r[wr_ptr_r] <= push_a;
    end
    if (push_n == 2'd2) begin
      buf_r[wr_ptr_nxt] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_nxt;
    end
  end

  assign head                  = buf_r[rd_ptr_r];
  assign out_res.valid         = (count_r != '0);
  assign out_res.event_res     = head.ev;
  assign out_res.out_channel   = head.ch;
  assign out_res.data          = head.data;
  assign out_res.segment_empty = head.empty;
  assign out_res.last          = head.last;

endmodule

`default_nettype wire

// ===== sv/chat_frame_deframer_liveness_top.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer with peer liveness tracking
// Per-channel frame parser and idle timer kept in a small state memory.
// ----------------------------------------------------------------------------
// Usage:
//   in_req carries one request per item: a received byte on a channel, or a
//   one-second tick. out_res delivers the events the requests cause, with
//   last set on the final event an item causes. The cfg_* port writes the
//   ping and timeout limits; the user must use it only while idle, as the
//   block does not enforce this. Bytes stream in at one per cycle while the
//   result queue has room. A tick walks the state memory one channel per
//   cycle while the queue has room, holding the update stage until the walk
//   ends, as the state memory has a single read port. The events of a byte
//   pass the update stage register and the result queue before out_res
//   offers them. A tick pushes an event early only once a later one is
//   known, so its final event, with last, waits for the end of the walk.
//   Reset clears the pipeline, the result queue, the ping counter and the valid
//   bit of every memory entry, so every channel starts idle and not alive; the
//   limits return to two and five seconds. No clearing pass is needed.
//   When out_res stalls, results gather in a four-entry queue; the update stage
//   holds once the queue cannot take two more, and in_req then drops ready.
// ----------------------------------------------------------------------------
`default_nettype none

module chat_frame_deframer_liveness_top #(
  parameter int CHANNELS      = cfdl_pkg::CHANNELS_DEF,
  parameter int SEGMENT_BYTES = cfdl_pkg::SEGMENT_BYTES_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cfdl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfdl_pkg::CFG_DATA_W-1:0] cfg_data,
  cfdl_in_if.sink                              in_req,
  cfdl_out_if.source                           out_res
);

  // Address width of the state memory; one bit even for a single channel.
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [cfdl_pkg::CFG_DATA_W-1:0] ping_after_r;
  logic [cfdl_pkg::CFG_DATA_W-1:0] timeout_after_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_after_r    <= cfdl_pkg::PING_AFTER_RST;
      timeout_after_r <= cfdl_pkg::TIMEOUT_AFTER_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cfdl_pkg::CFG_PING_AFTER:    ping_after_r    <= cfg_data;
        cfdl_pkg::CFG_TIMEOUT_AFTER: timeout_after_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Update stage registers. The stage holds one item; a tick stays here while
  // s1_addr_r walks the memory channel by channel.
  logic                 s1_valid_r;
  cfdl_pkg::op_t        s1_op_r;
  logic                 s1_ch_r;
  logic [7:0]           s1_byte_r;
  logic                 s1_ign_r;
  logic [AW-1:0]        s1_addr_r;

  logic                 accept;
  logic                 fire;
  logic                 item_end;
  logic                 space_ok;
  logic                 in_ign;
  logic [AW-1:0]        in_addr;
  logic [AW-1:0]        rd_addr;

  // State memory with its per-entry valid bits and one-deep write forwarding.
  cfdl_pkg::entry_t     state_mem [CHANNELS];
  logic [CHANNELS-1:0]  vld_r;
  cfdl_pkg::entry_t     rd_data_r;
  logic                 rd_vld_r;
  logic                 wb_valid_r;
  logic [AW-1:0]        wb_addr_r;
  cfdl_pkg::entry_t     wb_data_r;
  logic                 wr_en;
  cfdl_pkg::entry_t     cur;
  cfdl_pkg::entry_t     nxt;

  logic [cfdl_pkg::CNT_W-1:0] ping_s_r;
  logic [cfdl_pkg::CNT_W-1:0] ping_s_nxt;

  // New results of the current step, and the result held back during a tick
  // until it is known whether a later channel adds another one.
  cfdl_pkg::res_t       r0;
  cfdl_pkg::res_t       r1;
  logic [1:0]           nr;
  logic                 pend_v_r;
  cfdl_pkg::res_t       pend_r;
  cfdl_pkg::res_t       l0;
  cfdl_pkg::res_t       l1;
  logic [1:0]           tot;
  logic [1:0]           push_n;
  cfdl_pkg::res_t       push_a;
  cfdl_pkg::res_t       push_b;

  // A byte on a channel beyond CHANNELS passes through without any effect.
  assign in_ign  = (in_req.operation == cfdl_pkg::OP_BYTE) &&
                   (32'(in_req.channel) >= CHANNELS);
  assign in_addr = ((in_req.operation == cfdl_pkg::OP_TICK) || in_ign) ?
                   '0 : AW'(in_req.channel);

  assign fire     = s1_valid_r && space_ok;
  assign item_end = (s1_op_r == cfdl_pkg::OP_BYTE) || (s1_addr_r == AW'(CHANNELS - 1));
  assign in_req.ready = !s1_valid_r || (fire && item_end);
  assign accept   = in_req.valid && in_req.ready;

  // The memory is read every cycle at the entry the update stage needs next.
  always_comb begin
    if (accept) begin
      rd_addr = in_addr;
    end else if (fire && !item_end) begin
      rd_addr = s1_addr_r + AW'(1);
    end else begin
      rd_addr = s1_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (fire && item_end) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= cfdl_pkg::op_t'(in_req.operation);
      s1_ch_r   <= in_req.channel;
      s1_byte_r <= in_req.rx_byte;
      s1_ign_r  <= in_ign;
      s1_addr_r <= in_addr;
    end else if (fire && !item_end) begin
      s1_addr_r <= s1_addr_r + AW'(1);
    end
  end

  assign wr_en = fire && !s1_ign_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      state_mem[s1_addr_r] <= nxt;
    end
    rd_data_r <= state_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r      <= '0;
      rd_vld_r   <= 1'b0;
      wb_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
      rd_vld_r   <= vld_r[rd_addr];
      wb_valid_r <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      wb_addr_r <= s1_addr_r;
      wb_data_r <= nxt;
    end
  end

  // A write at the same edge as the read leaves stale data; take the written
  // entry instead. An entry never written reads as the reset state.
  always_comb begin
    if (wb_valid_r && (wb_addr_r == s1_addr_r)) begin
      cur = wb_data_r;
    end else if (rd_vld_r) begin
      cur = rd_data_r;
    end else begin
      cur = '0;
    end
  end

  // Step logic: next entry and up to two new results.
  always_comb begin
    logic [cfdl_pkg::CNT_W:0]    cnt_inc;
    logic [cfdl_pkg::SEEN_W-1:0] seen_inc;
    cfdl_pkg::event_t            end_ev;
    cfdl_pkg::res_t              tres;

    nxt        = cur;
    ping_s_nxt = ping_s_r;
    r0         = '0;
    r1         = '0;
    nr         = 2'd0;
    cnt_inc    = '0;
    seen_inc   = cur.seen + cfdl_pkg::SEEN_W'(1);
    end_ev     = cur.is_name ? cfdl_pkg::EV_NAME_END : cfdl_pkg::EV_MSG_END;
    tres       = '0;

    if (s1_op_r == cfdl_pkg::OP_TICK) begin
      // The shared ping counter advances on the first channel of the walk.
      if (s1_addr_r == '0) begin
        cnt_inc = {1'b0, ping_s_r} + (cfdl_pkg::CNT_W+1)'(1);
        if (cnt_inc > {1'b0, ping_after_r}) begin
          r0.ev      = cfdl_pkg::EV_PING;
          nr         = 2'd1;
          ping_s_nxt = '0;
        end else if (cnt_inc > {1'b0, cfdl_pkg::CNT_MAX}) begin
          ping_s_nxt = cfdl_pkg::CNT_MAX;
        end else begin
          ping_s_nxt = cnt_inc[cfdl_pkg::CNT_W-1:0];
        end
      end
      if (cur.alive) begin
        cnt_inc = {1'b0, cur.idle} + (cfdl_pkg::CNT_W+1)'(1);
        if (cnt_inc > {1'b0, timeout_after_r}) begin
          tres.ev        = cfdl_pkg::EV_TIMEOUT;
          tres.ch        = s1_addr_r[0];
          nxt.alive      = 1'b0;
          nxt.name_known = 1'b0;
          nxt.idle       = '0;
          if (nr == 2'd0) begin
            r0 = tres;
          end else begin
            r1 = tres;
          end
          nr = nr + 2'd1;
        end else if (cnt_inc > {1'b0, cfdl_pkg::CNT_MAX}) begin
          nxt.idle = cfdl_pkg::CNT_MAX;
        end else begin
          nxt.idle = cnt_inc[cfdl_pkg::CNT_W-1:0];
        end
      end
    end else if (!s1_ign_r) begin
      r0.ch = s1_ch_r;
      r1.ch = s1_ch_r;
      unique case (cur.phase)
        cfdl_pkg::PH_IDLE: begin
          if (s1_byte_r == cfdl_pkg::ESCAPE_BYTE) begin
            nxt.phase = cfdl_pkg::PH_ESCAPED;
          end else begin
            nxt.phase = cfdl_pkg::PH_IDLE;
            nxt.held  = '0;
            nxt.alive = 1'b1;
            nxt.idle  = '0;
          end
        end
        cfdl_pkg::PH_ESCAPED: begin
          if ((s1_byte_r == cfdl_pkg::CHR_MSG) || (s1_byte_r == cfdl_pkg::CHR_NAME)) begin
            nxt.phase   = cfdl_pkg::PH_LENGTH;
            nxt.is_name = (s1_byte_r == cfdl_pkg::CHR_NAME);
            nxt.seen    = '0;
            nxt.held    = '0;
          end else if (s1_byte_r == cfdl_pkg::CHR_PING) begin
            nxt.phase = cfdl_pkg::PH_TRAILER;
            if (!cur.alive || cur.name_known) begin
              r0.ev = cfdl_pkg::EV_WHO;
              nr    = 2'd1;
            end
          end else if (s1_byte_r == cfdl_pkg::CHR_WAVE) begin
            nxt.phase = cfdl_pkg::PH_TRAILER;
            r0.ev     = cfdl_pkg::EV_HANDSHAKE;
            nr        = 2'd1;
          end else begin
            nxt.phase = cfdl_pkg::PH_IDLE;
            nxt.held  = '0;
            nxt.alive = 1'b1;
            nxt.idle  = '0;
          end
        end
        cfdl_pkg::PH_LENGTH: begin
          if (s1_byte_r == 8'd0) begin
            // The peer leaves: no end event and no touch.
            r0.ev          = cfdl_pkg::EV_LEFT;
            nr             = 2'd1;
            nxt.alive      = 1'b0;
            nxt.name_known = 1'b0;
            nxt.phase      = cfdl_pkg::PH_IDLE;
            nxt.held       = '0;
          end else if (s1_byte_r[7]) begin
            nxt.phase = cfdl_pkg::PH_IDLE;
            nxt.held  = '0;
            nxt.alive = 1'b1;
            nxt.idle  = '0;
          end else begin
            nxt.length = s1_byte_r[cfdl_pkg::LEN_W-1:0];
            nxt.seen   = '0;
            nxt.phase  = cfdl_pkg::PH_PAYLOAD;
          end
        end
        cfdl_pkg::PH_PAYLOAD: begin
          nxt.seen = seen_inc;
          nr       = 2'd1;
          if (seen_inc > cfdl_pkg::SEEN_W'(SEGMENT_BYTES)) begin
            // Over-long segment: the byte is dropped and the segment closes.
            r0.ev    = end_ev;
            r0.empty = (cur.held == '0);
            if (cur.is_name && (cur.held != '0)) begin
              nxt.name_known = 1'b1;
            end
            nxt.held  = '0;
            nxt.alive = 1'b1;
            nxt.idle  = '0;
          end else begin
            r0.ev    = cur.is_name ? cfdl_pkg::EV_NAME_BYTE : cfdl_pkg::EV_MSG_BYTE;
            r0.data  = s1_byte_r;
            nxt.held = cur.held + cfdl_pkg::HELD_W'(1);
          end
          // The last payload byte also closes the segment and ends the frame.
          if (seen_inc >= {1'b0, cur.length}) begin
            r1.ev    = end_ev;
            r1.empty = (nxt.held == '0);
            if (cur.is_name && (nxt.held != '0)) begin
              nxt.name_known = 1'b1;
            end
            nxt.held  = '0;
            nxt.alive = 1'b1;
            nxt.idle  = '0;
            nxt.phase = cfdl_pkg::PH_IDLE;
            nr        = 2'd2;
          end
        end
        default: begin
          // Trailer byte, and any phase code that means nothing.
          nxt.phase = cfdl_pkg::PH_IDLE;
          nxt.held  = '0;
          nxt.alive = 1'b1;
          nxt.idle  = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ping_s_r <= '0;
    end else if (fire && (s1_op_r == cfdl_pkg::OP_TICK)) begin
      ping_s_r <= ping_s_nxt;
    end
  end

  // Result ordering. The held result goes first, then the new ones. At the end
  // of an item everything is pushed and the final one carries last; otherwise
  // the final one is held back.
  assign tot = nr + {1'b0, pend_v_r};
  assign l0  = pend_v_r ? pend_r : r0;
  assign l1  = pend_v_r ? r0 : r1;

  always_comb begin
    push_a = l0;
    push_b = l1;
    push_n = 2'd0;
    if (fire) begin
      if (item_end) begin
        push_n = tot;
        if (tot == 2'd1) begin
          push_a.last = 1'b1;
        end
        if (tot == 2'd2) begin
          push_b.last = 1'b1;
        end
      end else if (tot == 2'd2) begin
        push_n = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (fire) begin
      pend_v_r <= !item_end && (tot != 2'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && !item_end) begin
      if (tot == 2'd2) begin
        pend_r <= l1;
      end else if (tot == 2'd1) begin
        pend_r <= l0;
      end
    end
  end

  cfdl_res_fifo u_res_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push_a   (push_a),
    .push_b   (push_b),
    .space_ok (space_ok),
    .out_res  (out_res)
  );

endmodule

`default_nettype wire

// ===== sv/cfdl_chk.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer port checker
// Watches the result channel of the deframer top level over time.
// ----------------------------------------------------------------------------
`default_nettype none

`include "chat_frame_deframer_liveness_top_defines.svh"

module cfdl_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_event,
  input wire logic       out_channel,
  input wire logic [7:0] out_data,
  input wire logic       out_empty
);

  `CFDL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `CFDL_ASSERT_NOW(a_event_known, clk, rst_n, out_valid, (out_event != cfdl_pkg::EV_NONE) && (out_event <= cfdl_pkg::EV_TIMEOUT), "result carries no event")

  `CFDL_ASSERT_NOW(a_data_zero, clk, rst_n, out_valid && (out_event != cfdl_pkg::EV_MSG_BYTE) && (out_event != cfdl_pkg::EV_NAME_BYTE), out_data == 8'd0, "data on a non-byte event")

  `CFDL_ASSERT_NOW(a_empty_end, clk, rst_n, out_valid && out_empty, (out_event == cfdl_pkg::EV_MSG_END) || (out_event == cfdl_pkg::EV_NAME_END), "empty flag on a non-end event")

  `CFDL_ASSERT_NOW(a_ping_chan, clk, rst_n, out_valid && (out_event == cfdl_pkg::EV_PING), out_channel == 1'b0, "ping request on a nonzero channel")

endmodule

bind chat_frame_deframer_liveness_top cfdl_chk u_cfdl_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_event   (out_res.event_res),
  .out_channel (out_res.out_channel),
  .out_data    (out_res.data),
  .out_empty   (out_res.segment_empty)
);

`default_nettype wire

// ===== tb/sv/chat_frame_deframer_liveness_top_test.sv =====
// ----------------------------------------------------------------------------
// Chat frame deframer testbench
// Drives received bytes and one-second ticks into the deframer and checks
// every result event against a cycle-free model of the frame parsers, the
// peer liveness timers and the ping counter, under several limit settings
// and several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module chat_frame_deframer_liveness_top_test;
  import cfdl_pkg::*;

  // Register indexes that the block has no register for; writes to them
  // must leave both limits alone.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // The events of a byte leave after the update stage and the result queue,
  // and those of a tick once it has walked both channels; DRAIN_CYCLES covers
  // any work in flight.
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  // --------------------------------------------------------------------------
  // Event ledger: keeps its own copy of the parser and liveness state, works
  // out the events each accepted request must cause, and checks arriving
  // events in order against them.
  // --------------------------------------------------------------------------
  class event_ledger;
    logic [CFG_DATA_W-1:0] ping_after;
    logic [CFG_DATA_W-1:0] timeout_after;
    phase_t                phase     [CHANNELS_DEF];
    logic                  is_name   [CHANNELS_DEF];
    logic [LEN_W-1:0]      frame_len [CHANNELS_DEF];
    logic [SEEN_W-1:0]     seen      [CHANNELS_DEF];
    logic [HELD_W-1:0]     held      [CHANNELS_DEF];
    logic                  alive     [CHANNELS_DEF];
    logic                  known     [CHANNELS_DEF];
    logic [CNT_W-1:0]      idle      [CHANNELS_DEF];
    logic [CNT_W-1:0]      ping_cnt;
    res_t                  expected_q[$];
    int                    error_count;

    function new();
      ping_after    = PING_AFTER_RST;
      timeout_after = TIMEOUT_AFTER_RST;
      for (int i = 0; i < CHANNELS_DEF; i++) begin
        phase[i]     = PH_IDLE;
        is_name[i]   = 1'b0;
        frame_len[i] = '0;
        seen[i]      = '0;
        held[i]      = '0;
        alive[i]     = 1'b0;
        known[i]     = 1'b0;
        idle[i]      = '0;
      end
      ping_cnt    = '0;
      error_count = 0;
    endfunction

    function void write_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_PING_AFTER) begin
        ping_after = val;
      end else if (idx == CFG_TIMEOUT_AFTER) begin
        timeout_after = val;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void push_event(event_t ev, logic ch, logic [7:0] d, logic empty);
      res_t r;
      r.ev    = ev;
      r.ch    = ch;
      r.data  = d;
      r.empty = empty;
      r.last  = 1'b0;
      expected_q.push_back(r);
    endfunction

    function void touch(logic ch);
      alive[ch] = 1'b1;
      idle[ch]  = '0;
    endfunction

    function void abort_frame(logic ch);
      phase[ch] = PH_IDLE;
      held[ch]  = '0;
      touch(ch);
    endfunction

    function void close_segment(logic ch);
      push_event(is_name[ch] ? EV_NAME_END : EV_MSG_END, ch, 8'h00, held[ch] == '0);
      if (is_name[ch] && held[ch] != '0) begin
        known[ch] = 1'b1;
      end
      held[ch] = '0;
      touch(ch);
    endfunction

    function void note_request(op_t op, logic ch, logic [7:0] b);
      int   first;
      int   t;
      res_t tail;
      first = expected_q.size();
      if (op == OP_TICK) begin
        t = int'(ping_cnt) + 1;
        if (t > int'(ping_after)) begin
          push_event(EV_PING, 1'b0, 8'h00, 1'b0);
          ping_cnt = '0;
        end else begin
          ping_cnt = (t > 15) ? CNT_MAX : CNT_W'(t);
        end
        for (int i = 0; i < CHANNELS_DEF; i++) begin
          if (alive[i]) begin
            t = int'(idle[i]) + 1;
            if (t > int'(timeout_after)) begin
              push_event(EV_TIMEOUT, i[0], 8'h00, 1'b0);
              alive[i] = 1'b0;
              known[i] = 1'b0;
              idle[i]  = '0;
            end else begin
              idle[i] = (t > 15) ? CNT_MAX : CNT_W'(t);
            end
          end
        end
      end else begin
        case (phase[ch])
          PH_IDLE: begin
            if (b == ESCAPE_BYTE) begin
              phase[ch] = PH_ESCAPED;
            end else begin
              abort_frame(ch);
            end
          end
          PH_ESCAPED: begin
            if (b == CHR_MSG || b == CHR_NAME) begin
              phase[ch]   = PH_LENGTH;
              is_name[ch] = (b == CHR_NAME);
              seen[ch]    = '0;
              held[ch]    = '0;
            end else if (b == CHR_PING) begin
              phase[ch] = PH_TRAILER;
              if (!alive[ch] || known[ch]) begin
                push_event(EV_WHO, ch, 8'h00, 1'b0);
              end
            end else if (b == CHR_WAVE) begin
              phase[ch] = PH_TRAILER;
              push_event(EV_HANDSHAKE, ch, 8'h00, 1'b0);
            end else begin
              abort_frame(ch);
            end
          end
          PH_LENGTH: begin
            if (b == 8'h00) begin
              // The peer says goodbye: no end event and no touch.
              push_event(EV_LEFT, ch, 8'h00, 1'b0);
              alive[ch] = 1'b0;
              known[ch] = 1'b0;
              phase[ch] = PH_IDLE;
              held[ch]  = '0;
            end else if (b[7]) begin
              abort_frame(ch);
            end else begin
              frame_len[ch] = b[LEN_W-1:0];
              seen[ch]      = '0;
              phase[ch]     = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            seen[ch] = seen[ch] + 1'b1;
            // Bytes past the segment size are dropped, each closing a segment.
            if (int'(seen[ch]) > SEGMENT_BYTES_DEF) begin
              close_segment(ch);
            end else begin
              push_event(is_name[ch] ? EV_NAME_BYTE : EV_MSG_BYTE, ch, b, 1'b0);
              held[ch] = held[ch] + 1'b1;
            end
            if (seen[ch] >= {1'b0, frame_len[ch]}) begin
              close_segment(ch);
              phase[ch] = PH_IDLE;
            end
          end
          default: begin
            abort_frame(ch);
          end
        endcase
      end
      if (expected_q.size() > first) begin
        tail      = expected_q.pop_back();
        tail.last = 1'b1;
        expected_q.push_back(tail);
      end
    endfunction

    function void check_event(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("unexpected event: ev=%0d ch=%0d data=%02h empty=%0b last=%0b",
                   got.ev, got.ch, got.data, got.empty, got.last);
        end
        return;
      end
      want = expected_q.pop_front();
      if (got.ev !== want.ev || got.ch !== want.ch || got.data !== want.data ||
          got.empty !== want.empty || got.last !== want.last) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("event mismatch: expected ev=%0d ch=%0d data=%02h empty=%0b last=%0b",
                   want.ev, want.ch, want.data, want.empty, want.last);
          $display("                actual   ev=%0d ch=%0d data=%02h empty=%0b last=%0b",
                   got.ev, got.ch, got.data, got.empty, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, configuration port, channels and the block itself.
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfdl_in_if  in_if ();
  cfdl_out_if out_if ();

  chat_frame_deframer_liveness_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_req   (in_if),
    .out_res  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  event_ledger ledger;

  // Traffic shaping knobs, set by the main sequence between phases.
  int idle_pct;
  int stall_pct;
  int hold_gen;
  bit want_max_frame;

  // Bytes of partly sent sequences, one queue per receive channel, so that
  // the two parsers see interleaved traffic.
  logic [7:0] pend0_q[$];
  logic [7:0] pend1_q[$];
  int tick_burst_left;

  // --------------------------------------------------------------------------
  // Receiver: stalls at random by stall_pct. When the main sequence bumps
  // hold_gen, it holds ready low for a long stretch, counted here, so the
  // result queue fills and the block pushes back on its request channel.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int seen_gen;
    int hold_left;
    seen_gen  = 0;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_gen != seen_gen) begin
        seen_gen  = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled at the rising edge, so both the accepted
  // request and the accepted event of a cycle are seen as they were just
  // before the edge. An event can never stem from the request taken at the
  // same edge, so the order of the two calls does not matter.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    res_t got;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.ev    = event_t'(out_if.event_res);
        got.ch    = out_if.out_channel;
        got.data  = out_if.data;
        got.empty = out_if.segment_empty;
        got.last  = out_if.last;
        ledger.check_event(got);
      end
      if (in_if.valid && in_if.ready) begin
        ledger.note_request(op_t'(in_if.operation), in_if.channel, in_if.rx_byte);
      end
    end
  end

  // Watchdog: a long run of cycles in which neither side moves a request
  // means the block has hung.
  int quiet_cycles;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Driving tasks.
  // --------------------------------------------------------------------------

  // Offers one request, after a random number of idle cycles, and returns at
  // the edge where it is taken. Valid stays high on return; the next call
  // either replaces the payload or drops valid for a gap.
  task automatic send_req(input op_t op, input logic ch, input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.operation <= op;
    in_if.channel   <= ch;
    in_if.rx_byte   <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
  endtask

  task automatic send_byte(input logic ch, input logic [7:0] b);
    send_req(OP_BYTE, ch, b);
  endtask

  // The channel and byte fields of a tick are don't-cares; fill them at random.
  task automatic send_tick();
    send_req(OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)));
  endtask

  // Drops valid, waits for every expected event, then lets any work that
  // causes no event finish so the block is truly idle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    ledger.write_limit(idx, val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Appends one random sequence to a channel's queue. Most are well-formed
  // frames, pings and waves with random content; the rest are aborts, goodbyes
  // and noise, and noise may break whatever sequence follows it.
  task automatic add_sequence(input logic ch);
    logic [7:0] seq[$];
    int kind;
    int len;
    kind = $urandom_range(99);
    seq.push_back(ESCAPE_BYTE);
    if (kind < 42) begin
      seq.push_back($urandom_range(1) ? CHR_NAME : CHR_MSG);
      len = $urandom_range(99);
      if (want_max_frame) begin
        want_max_frame = 1'b0;
        len = 127;
      end else if (len < 70) begin
        len = $urandom_range(4, 1);
      end else if (len < 90) begin
        // Around the segment size, where dropping and double ends happen.
        len = $urandom_range(SEGMENT_BYTES_DEF + 3, SEGMENT_BYTES_DEF - 1);
      end else begin
        len = $urandom_range(SEGMENT_BYTES_DEF - 2, 5);
      end
      seq.push_back(8'(len));
      repeat (len) seq.push_back(8'($urandom_range(255)));
    end else if (kind < 54) begin
      seq.push_back(CHR_PING);
      seq.push_back(8'($urandom_range(255)));
    end else if (kind < 64) begin
      seq.push_back(CHR_WAVE);
      seq.push_back(8'($urandom_range(255)));
    end else if (kind < 72) begin
      seq.push_back($urandom_range(1) ? CHR_NAME : CHR_MSG);
      seq.push_back(8'h00);
    end else if (kind < 80) begin
      seq.push_back($urandom_range(1) ? CHR_NAME : CHR_MSG);
      seq.push_back(8'($urandom_range(255, 128)));
    end else if (kind < 86) begin
      seq.push_back(8'($urandom_range(255)));
    end else begin
      seq.delete();
      repeat ($urandom_range(3, 1)) seq.push_back(8'($urandom_range(255)));
    end
    foreach (seq[k]) begin
      if (ch) begin
        pend1_q.push_back(seq[k]);
      end else begin
        pend0_q.push_back(seq[k]);
      end
    end
  endtask

  // Sends a number of random requests: mostly bytes taken from the two
  // channel queues in random order, with single ticks and bursts of ticks
  // long enough to reach the largest ping and timeout limits.
  task automatic run_items(input int count);
    int r;
    logic ch;
    logic [7:0] b;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(99);
      if (tick_burst_left == 0 && r < 2) begin
        tick_burst_left = $urandom_range(17, 2);
      end
      if (tick_burst_left > 0) begin
        tick_burst_left--;
        send_tick();
      end else if (r < 8) begin
        send_tick();
      end else begin
        ch = 1'($urandom_range(1));
        if (ch && pend1_q.size() == 0) add_sequence(ch);
        if (!ch && pend0_q.size() == 0) add_sequence(ch);
        b = ch ? pend1_q.pop_front() : pend0_q.pop_front();
        send_byte(ch, b);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n            <= 1'b0;
    cfg_wr_en        <= 1'b0;
    cfg_index        <= CFG_PING_AFTER;
    cfg_data         <= '0;
    in_if.valid      <= 1'b0;
    in_if.operation  <= OP_BYTE;
    in_if.channel    <= 1'b0;
    in_if.rx_byte    <= 8'h00;
    idle_pct         = 0;
    stall_pct        = 0;
    hold_gen         = 0;
    want_max_frame   = 1'b0;
    tick_burst_left  = 0;
    ledger           = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset limits (ping after 2 s, timeout after 5 s).
    // A stray byte while idle makes channel 0 alive without any event.
    send_byte(1'b0, 8'h00);
    // Ping from a peer not yet alive asks who it is; the trailer is absorbed.
    send_byte(1'b1, ESCAPE_BYTE);
    send_byte(1'b1, CHR_PING);
    send_byte(1'b1, 8'hA5);
    // Ping from a live peer with no known name: no who request.
    send_byte(1'b0, ESCAPE_BYTE);
    send_byte(1'b0, CHR_PING);
    send_byte(1'b0, 8'hFF);
    // Wave requests a handshake; an escape used as trailer is just a trailer.
    send_byte(1'b0, ESCAPE_BYTE);
    send_byte(1'b0, CHR_WAVE);
    send_byte(1'b0, ESCAPE_BYTE);
    // Two-byte name frame at the byte extremes; the last byte also closes it.
    send_byte(1'b1, ESCAPE_BYTE);
    send_byte(1'b1, CHR_NAME);
    send_byte(1'b1, 8'd2);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hFF);
    // Now that the name is known, a ping asks who again.
    send_byte(1'b1, ESCAPE_BYTE);
    send_byte(1'b1, CHR_PING);
    send_byte(1'b1, 8'h80);
    // A length of 128 aborts the frame.
    send_byte(1'b0, ESCAPE_BYTE);
    send_byte(1'b0, CHR_MSG);
    send_byte(1'b0, 8'h80);
    // Zero length: the peer has left.
    send_byte(1'b1, ESCAPE_BYTE);
    send_byte(1'b1, CHR_MSG);
    send_byte(1'b1, 8'h00);
    // The third tick passes the ping limit.
    repeat (3) send_tick();

    // Phase one: reset limits, no idling on either side.
    run_items(50);
    wait_idle();

    // Phase two: lowest limits, so every tick pings and times out any live
    // peer. Writes to unused indexes must change nothing. The sender idles.
    write_reg(CFG_PING_AFTER, 4'd0);
    write_reg(CFG_TIMEOUT_AFTER, 4'd0);
    write_reg(CFG_SPARE_A, 4'($urandom_range(15)));
    write_reg(CFG_SPARE_B, 4'($urandom_range(15)));
    idle_pct       = 54;
    stall_pct      = 0;
    want_max_frame = 1'b1;
    run_items(50);
    wait_idle();

    // Phase three: highest limits; the receiver stalls.
    write_reg(CFG_PING_AFTER, 4'd15);
    write_reg(CFG_TIMEOUT_AFTER, 4'd15);
    idle_pct  = 0;
    stall_pct = 54;
    run_items(50);
    wait_idle();

    // Phase four: random limits, both sides idle now and then. In the middle
    // the receiver holds off for a long stretch while the sender keeps
    // offering requests back to back, then the sender waits for every event.
    write_reg(CFG_PING_AFTER, 4'($urandom_range(15)));
    write_reg(CFG_TIMEOUT_AFTER, 4'($urandom_range(15)));
    idle_pct  = 25;
    stall_pct = 25;
    run_items(25);
    hold_gen++;
    idle_pct = 0;
    run_items(40);
    idle_pct = 25;
    wait_idle();
    run_items(25);

    wait_idle();
    if (ledger.error_count == 0 && ledger.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
